### rtl/dsec_pkg.sv
package dsec_pkg;

    localparam int unsigned COORD_W   = 8;
    localparam int unsigned HEADING_W = 4;
    localparam int unsigned NUM_TH    = 4;
    localparam int unsigned TH_W      = 9;
    localparam int unsigned SCALED_W  = 15;
    localparam int unsigned LIMIT_W   = 17;

    localparam logic [6:0] RATIO_SCALE = 7'd100;

    localparam logic [TH_W-1:0] THRESH [NUM_TH] = '{9'd20, 9'd67, 9'd150, 9'd503};

    localparam logic [HEADING_W-1:0] HEADING_UP    = 4'd0;
    localparam logic [HEADING_W-1:0] HEADING_RIGHT = 4'd4;
    localparam logic [HEADING_W-1:0] HEADING_DOWN  = 4'd8;
    localparam logic [HEADING_W-1:0] HEADING_LEFT  = 4'd12;

    typedef struct packed {
        logic                 axis;
        logic [HEADING_W-1:0] base;
        logic [COORD_W-1:0]   num;
        logic [COORD_W-1:0]   den;
    } class_t;

    typedef struct packed {
        logic                 axis;
        logic [HEADING_W-1:0] base;
        logic [SCALED_W-1:0]  scaled;
    } scaled_t;

endpackage

### rtl/coord_if.sv
interface coord_if;
    import dsec_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;

    modport source (output valid, output start_x, output start_y, output target_x,
                    output target_y, input ready);
    modport sink (input valid, input start_x, input start_y, input target_x,
                  input target_y, output ready);
endinterface

### rtl/heading_if.sv
interface heading_if;
    import dsec_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [HEADING_W-1:0] heading;

    modport source (output valid, output heading, input ready);
    modport sink (input valid, input heading, output ready);
endinterface

### rtl/dsec_classify.sv
module dsec_classify
    import dsec_pkg::*;
(
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] target_x,
    input  logic [COORD_W-1:0] target_y,
    output class_t             cls
);

    logic               left;
    logic               below;
    logic               swap;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;

    always_comb
    begin
        left  = (target_x < start_x);
        below = (target_y > start_y);
        swap  = left ^ below;
        dx    = left ? (start_x - target_x) : (target_x - start_x);
        dy    = below ? (target_y - start_y) : (start_y - target_y);

        cls.axis = 1'b0;
        cls.base = {left, swap, 2'b00};
        cls.num  = swap ? dy : dx;
        cls.den  = swap ? dx : dy;

        if (start_x == target_x)
        begin
            cls.axis = 1'b1;
            cls.base = below ? HEADING_DOWN : HEADING_UP;
        end
        else if (start_y == target_y)
        begin
            cls.axis = 1'b1;
            cls.base = left ? HEADING_LEFT : HEADING_RIGHT;
        end
    end

endmodule

### rtl/direction_sector_16.sv
// Heading quantizer: for each transaction of a start and a target point in 8-bit
// screen coordinates it gives the direction from start to target as one of 16
// sectors, clockwise from 0 (up) through 4 (right), 8 (down) and 12 (left).
// Identical points give 0. The ratio test 100*num/den >= T (num across the base
// direction, den along it) is done as 100*num >= T*den with constant multipliers,
// so no divider is needed. Three register stages (classify, scale, compare); one
// transaction is accepted per clock while the output side does not stall, and a
// result passes through the classify, scale and compare registers in that order.
// A stall holds an occupied stage only while all later stages are occupied too.
module direction_sector_16
    import dsec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    coord_if.sink    in,
    heading_if.source out
);

    class_t                  cls;
    class_t                  s1_reg;
    scaled_t                 s2_reg;
    logic [LIMIT_W-1:0]      limit_reg [NUM_TH];
    logic [HEADING_W-1:0]    heading_reg;
    logic [HEADING_W-1:0]    heading_next;
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    rdy1;
    logic                    rdy2;
    logic                    rdy3;

    dsec_classify u_classify (
        .start_x  (in.start_x),
        .start_y  (in.start_y),
        .target_x (in.target_x),
        .target_y (in.target_y),
        .cls      (cls)
    );

    assign rdy3     = !v3_reg || out.ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in.ready = rdy1;

    assign out.valid   = v3_reg;
    assign out.heading = heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in.valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: classification
    always_ff @(posedge clk)
    begin
        if (rdy1 && in.valid)
        begin
            s1_reg <= cls;
        end
    end

    // stage 2: scaled minor distance and threshold limits
    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            s2_reg.axis   <= s1_reg.axis;
            s2_reg.base   <= s1_reg.base;
            s2_reg.scaled <= SCALED_W'(s1_reg.num) * SCALED_W'(RATIO_SCALE);
            for (int i = 0; i < NUM_TH; i++)
            begin
                limit_reg[i] <= LIMIT_W'(s1_reg.den) * LIMIT_W'(THRESH[i]);
            end
        end
    end

    // stage 3: threshold count, wraps modulo 16
    always_comb
    begin
        heading_next = s2_reg.base;
        if (!s2_reg.axis)
        begin
            for (int i = 0; i < NUM_TH; i++)
            begin
                if (LIMIT_W'(s2_reg.scaled) >= limit_reg[i])
                begin
                    heading_next = heading_next + HEADING_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            heading_reg <= heading_next;
        end
    end

    a_nonzero_major: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !s1_reg.axis |-> s1_reg.den != '0)
        else $error("off-axis transaction with zero major distance");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v1_reg && !v2_reg && !v3_reg |-> in.ready)
        else $error("empty pipeline refuses a transaction");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !rdy2 |=> v2_reg && $stable(s2_reg))
        else $error("stalled stage 2 lost its transaction");

endmodule
